// ===== sv/tspf_pkg.sv =====
package tspf_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BLOCK_BYTES_W = 20;
  localparam int unsigned PID_W         = 13;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned COMP_N        = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 13;

  // output queue: one header burst plus steady one-word flow
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;
  localparam int unsigned BURST_N    = 3;

  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'h47;
  localparam logic [4:0]        PID_HI_MASK   = 5'h1f;
  localparam logic [PID_W-1:0]  PID_PAT       = 13'h0000;
  localparam logic [PID_W-1:0]  PID_CAT       = 13'h0001;
  localparam logic [PID_W-1:0]  PID_SDT       = 13'h0011;
  localparam logic [PID_W-1:0]  PID_EIT       = 13'h0012;
  localparam logic [PID_W-1:0]  PID_TDT       = 13'h0014;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE   = 3'd0,
    CFG_PMT_PID         = 3'd1,
    CFG_PCR_PID         = 3'd2,
    CFG_COMPONENT_COUNT = 3'd3,
    CFG_COMPONENT_PID_A = 3'd4,
    CFG_COMPONENT_PID_B = 3'd5,
    CFG_COMPONENT_PID_C = 3'd6,
    CFG_COMPONENT_PID_D = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                         filter_enable;
    logic [PID_W-1:0]             pmt_pid;
    logic [PID_W-1:0]             pcr_pid;
    logic [COUNT_W-1:0]           component_count;
    logic [COMP_N-1:0][PID_W-1:0] component_pid;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        data_byte;
    logic                     block_start;
    logic [BLOCK_BYTES_W-1:0] block_bytes;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              packet_first;
  } out_word_t;

  typedef struct packed {
    logic [1:0]                n;
    out_word_t [BURST_N-1:0]   word;
  } push_t;

  function automatic logic pid_selected(cfg_t c, logic [PID_W-1:0] pid);
    logic hit;
    hit = (c.filter_enable == 1'b0) ||
          (pid == PID_PAT) || (pid == PID_CAT) || (pid == PID_SDT) ||
          (pid == PID_EIT) || (pid == PID_TDT) ||
          (pid == c.pmt_pid) || (pid == c.pcr_pid);
    // a count above four enables all four slots
    for (int i = 0; i < COMP_N; i++) begin
      if ((c.component_count > COUNT_W'(i)) && (c.component_pid[i] == pid)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== sv/tspf_fifo.sv =====
module tspf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tspf_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tspf_pkg::out_word_t out_word_o
);
  import tspf_pkg::*;

  out_word_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  // a full burst must fit without counting the word leaving this cycle
  assign room_o      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - BURST_N));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    count_d  = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BURST_N; k++) begin
      if (push_i.n > 2'(k)) begin
        mem_q[wr_ptr_q + FIFO_PTR_W'(k)] <= push_i.word[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue count beyond depth");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (FIFO_CNT_W'(push_i.n) + count_q <= FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("push overflows output queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[FIFO_PTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== sv/tspf_parse.sv =====
module tspf_parse #(
  parameter int unsigned PACKET_BYTES    = 188,
  parameter int unsigned MAX_BLOCK_BYTES = 1048575
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tspf_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tspf_pkg::in_word_t in_word_i,
  input  logic               room_i,
  output tspf_pkg::push_t    push_o
);
  import tspf_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned CMP_W = ((OFF_W > BLOCK_BYTES_W) ? OFF_W : BLOCK_BYTES_W) + 1;
  localparam int unsigned POS_W = $clog2(PACKET_BYTES);

  localparam logic [CMP_W-1:0] MAX_LEN    = CMP_W'(MAX_BLOCK_BYTES);
  localparam logic [CMP_W-1:0] PKT_LEN    = CMP_W'(PACKET_BYTES);
  localparam logic [OFF_W-1:0] MAX_OFF    = OFF_W'(MAX_BLOCK_BYTES);
  localparam logic [POS_W:0]   PKT_WRAP   = (POS_W + 1)'(PACKET_BYTES);

  in_word_t          word_q;
  logic              vld_q;
  logic              advance;

  logic [OFF_W-1:0]  off_q, off_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              keep_q, keep_d;
  logic [BYTE_W-1:0] hdr_q, hdr_d;

  logic [OFF_W-1:0]  offset;
  logic [POS_W-1:0]  pos;
  logic [POS_W:0]    pos_inc;
  logic [CMP_W-1:0]  len_c;
  logic              whole;
  logic [PID_W-1:0]  pid;
  push_t             push;

  assign advance    = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;
  assign push_o     = push;

  always_comb begin
    offset  = word_q.block_start ? '0 : off_q;
    pos     = word_q.block_start ? '0 : pos_q;
    len_c   = (CMP_W'(word_q.block_bytes) > MAX_LEN) ? MAX_LEN : CMP_W'(word_q.block_bytes);
    whole   = (CMP_W'(offset) + PKT_LEN) <= len_c;
    pid     = {hdr_q[4:0] & PID_HI_MASK, word_q.data_byte};
    pos_inc = {1'b0, pos} + (POS_W + 1)'(1);

    keep_d  = keep_q;
    hdr_d   = hdr_q;
    push    = '0;
    push.word[0].out_byte = word_q.data_byte;

    if (pos == POS_W'(0)) begin
      keep_d = whole && (word_q.data_byte == SYNC_BYTE);
    end else if (pos == POS_W'(1)) begin
      hdr_d = word_q.data_byte;
    end else if (pos == POS_W'(2)) begin
      if (keep_q) begin
        if (pid_selected(cfg_i, pid)) begin
          // sync byte and the two held header bytes go out together
          push.n                    = 2'd3;
          push.word[0].out_byte     = SYNC_BYTE;
          push.word[0].packet_first = 1'b1;
          push.word[1].out_byte     = hdr_q;
          push.word[2].out_byte     = word_q.data_byte;
        end else begin
          keep_d = 1'b0;
        end
      end
    end else if (keep_q) begin
      push.n = 2'd1;
    end

    pos_d = (pos_inc >= PKT_WRAP) ? '0 : pos_inc[POS_W-1:0];
    off_d = (offset < MAX_OFF) ? offset + OFF_W'(1) : offset;

    if (!advance) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
    if (advance) begin
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      off_q  <= '0;
      pos_q  <= '0;
      keep_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (advance) begin
        off_q  <= off_d;
        pos_q  <= pos_d;
        keep_q <= keep_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_burst_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd3) |-> (push.word[0].packet_first && push.word[0].out_byte == SYNC_BYTE))
    else $error("header burst does not open with sync word");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> (vld_q && room_i))
    else $error("push without a held word or queue room");

  a_single_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd1) |-> (!push.word[0].packet_first && keep_q))
    else $error("payload word flagged first or from a dropped packet");
`endif

endmodule

// ===== sv/ts_pid_packet_filter.sv =====
// order: a payload byte is held in the input register, then written to the output queue once
//   the queue has room and offered on out_valid_o; the three header bytes enter the queue
//   together after the third byte is registered and leave one per cycle while out_ready_i is high
// throughput: one byte per cycle; the eight-word output queue absorbs the header burst
//   and input stalls only when the queue holds more than five words
// reset: rst_ni clears registers, flags, position, offset and queue count; held header,
//   input word and queue storage are not reset
module ts_pid_packet_filter #(
  parameter int unsigned PACKET_BYTES    = 188,
  parameter int unsigned MAX_BLOCK_BYTES = 1048575
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tspf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tspf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tspf_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tspf_pkg::out_word_t                 out_word_o
);
  import tspf_pkg::*;

  cfg_t  cfg_q, cfg_d;
  push_t push;
  logic  room;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FILTER_ENABLE:   cfg_d.filter_enable    = cfg_data_i[0];
        CFG_PMT_PID:         cfg_d.pmt_pid          = cfg_data_i[PID_W-1:0];
        CFG_PCR_PID:         cfg_d.pcr_pid          = cfg_data_i[PID_W-1:0];
        CFG_COMPONENT_COUNT: cfg_d.component_count  = cfg_data_i[COUNT_W-1:0];
        CFG_COMPONENT_PID_A: cfg_d.component_pid[0] = cfg_data_i[PID_W-1:0];
        CFG_COMPONENT_PID_B: cfg_d.component_pid[1] = cfg_data_i[PID_W-1:0];
        CFG_COMPONENT_PID_C: cfg_d.component_pid[2] = cfg_data_i[PID_W-1:0];
        CFG_COMPONENT_PID_D: cfg_d.component_pid[3] = cfg_data_i[PID_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tspf_parse #(
    .PACKET_BYTES    (PACKET_BYTES),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .room_i     (room),
    .push_o     (push)
  );

  tspf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
